FILE: sv/urcr_pkg.sv
// Shared types and constants of the uniform row and column remover.
package urcr_pkg;

	localparam int REQ_W  = 2;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int PIX_W  = 4;
	localparam int SIZE_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_INVERT  = 2'd2,
		REQ_COMPACT = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		SW_NONE,
		SW_SCAN,
		SW_PACK,
		SW_CLEAR
	} sweep_t;

	typedef struct packed {
		logic   acc;
		logic   out_load;
		logic   inv_wb;
		logic   cmp_start;
		logic   set_size;
		sweep_t sweep;
	} urcr_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic img_empty;
	} urcr_sts_t;

endpackage

FILE: sv/urcr_req_if.sv
// Request channel: valid, ready and the request fields.
interface urcr_req_if;
	import urcr_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, req_type, row, col, pixel_in, input ready);
	modport sink   (input valid, req_type, row, col, pixel_in, output ready);
endinterface

FILE: sv/urcr_res_if.sv
// Result channel: valid, ready and the result fields.
interface urcr_res_if;
	import urcr_pkg::*;

	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel_out;
	logic [SIZE_W-1:0] cur_height;
	logic [SIZE_W-1:0] cur_width;
	logic              out_of_range;

	modport source (output valid, pixel_out, cur_height, cur_width, out_of_range, input ready);
	modport sink   (input valid, pixel_out, cur_height, cur_width, out_of_range, output ready);
endinterface

FILE: sv/urcr_ctrl.sv
// Controller: request handshake, result stage valids and the compaction sequencer.
module urcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_type,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  urcr_pkg::urcr_sts_t sts,
	output urcr_pkg::urcr_cmd_t cmd
);
	import urcr_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_RUN,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_PACK,
		ST_PACK_WAIT,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic   s1_vld_q;
	logic   s1_inv_q;
	logic   wb_q;
	logic   out_vld_q;
	logic   s1_mv;
	logic   rdy;
	logic   acc;
	logic   is_cmp;

	always_comb begin
		s1_mv  = s1_vld_q && (!out_vld_q || out_ready);
		rdy    = (state_q == ST_RUN) && (!s1_vld_q || (s1_mv && !s1_inv_q));
		acc    = in_valid && rdy;
		is_cmp = (in_type == REQ_COMPACT);

		cmd           = '0;
		cmd.acc       = acc;
		cmd.out_load  = s1_mv;
		cmd.inv_wb    = wb_q;
		cmd.cmp_start = acc && is_cmp;
		cmd.sweep     = SW_NONE;
		case (state_q)
			ST_INIT:      cmd.sweep = SW_CLEAR;
			ST_SCAN:      cmd.sweep = SW_SCAN;
			ST_PACK:      cmd.sweep = SW_PACK;
			ST_PACK_WAIT: cmd.set_size = 1'b1;
			ST_CLEAR:     cmd.sweep = SW_CLEAR;
			default:      cmd.sweep = SW_NONE;
		endcase
	end

	assign in_ready  = rdy;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			s1_vld_q  <= 1'b0;
			s1_inv_q  <= 1'b0;
			wb_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (acc && is_cmp) state_q <= sts.img_empty ? ST_PACK_WAIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.sweep_last) state_q <= ST_SCAN_WAIT;
				end
				ST_SCAN_WAIT: state_q <= ST_PACK;
				ST_PACK: begin
					if (sts.sweep_last) state_q <= ST_PACK_WAIT;
				end
				ST_PACK_WAIT: state_q <= ST_CLEAR;
				ST_CLEAR: begin
					if (sts.sweep_last) state_q <= ST_RUN;
				end
				default: state_q <= ST_INIT;
			endcase

			if (acc && !is_cmp) begin
				s1_vld_q <= 1'b1;
				s1_inv_q <= (in_type == REQ_INVERT);
			end else if (state_q == ST_CLEAR && sts.sweep_last) begin
				s1_vld_q <= 1'b1;
				s1_inv_q <= 1'b0;
			end else if (s1_mv) begin
				s1_vld_q <= 1'b0;
				s1_inv_q <= 1'b0;
			end

			wb_q <= acc && (in_type == REQ_INVERT);

			if (s1_mv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end
endmodule

FILE: sv/urcr_dp.sv
// Datapath: pixel store, image size, sweep counters, marks and result registers.
module urcr_dp #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  urcr_pkg::urcr_cmd_t           cmd,
	output urcr_pkg::urcr_sts_t           sts,
	input  logic [urcr_pkg::REQ_W-1:0]    req_type,
	input  logic [urcr_pkg::ROW_W-1:0]    row,
	input  logic [urcr_pkg::COL_W-1:0]    col,
	input  logic [urcr_pkg::PIX_W-1:0]    pixel_in,
	output logic [urcr_pkg::PIX_W-1:0]    pixel_out,
	output logic [urcr_pkg::SIZE_W-1:0]   cur_height,
	output logic [urcr_pkg::SIZE_W-1:0]   cur_width,
	output logic                          out_of_range
);
	import urcr_pkg::*;

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RC    = $clog2(GRID_ROWS + 1);
	localparam int CC    = $clog2(GRID_COLS + 1);
	localparam int RI    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CI    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CMPW  = 9;

	logic [PIX_W-1:0]  mem [DEPTH];
	logic [PIX_W-1:0]  rdata_q;

	logic [RC-1:0]     h_q, keep_h_q, r_q, dr_q, nh_q;
	logic [CC-1:0]     w_q, keep_w_q, c_q, dc_q, nw_q;

	logic              rz_q, ro_q;
	logic              rm_q [GRID_ROWS];
	logic              cz_q [GRID_COLS];
	logic              co_q [GRID_COLS];
	logic              rm_rd_q, cz_rd_q, co_rd_q;
	logic              fw_q, cz_fw_q, co_fw_q;

	logic              tg_scan_s1, tg_pack_s1, tg_rlast_s1, tg_clast_s1;
	logic [RI-1:0]     tg_r_s1;
	logic [CI-1:0]     tg_c_s1;

	logic [REQ_W-1:0]  s1_type_q;
	logic              s1_rd_ok_q, s1_oor_q, s1_ingrid_q;
	logic [AW-1:0]     s1_addr_q;

	logic [PIX_W-1:0]  pix_q;
	logic [SIZE_W-1:0] oh_q, ow_q;
	logic              oor_q;

	logic              in_grid, in_img;
	logic [AW-1:0]     acc_addr, swp_addr, dst_addr;
	logic [RC-1:0]     lim_r;
	logic [CC-1:0]     lim_c;
	logic              r_last, c_last;
	logic              cz_cur, co_cur;
	logic              copy;
	logic              vz, vo, rz_n, ro_n, cz_n, co_n;
	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [PIX_W-1:0]  wdata;

	always_comb begin
		in_grid  = (CMPW'(row) < CMPW'(GRID_ROWS)) && (CMPW'(col) < CMPW'(GRID_COLS));
		in_img   = in_grid && (CMPW'(row) < CMPW'(h_q)) && (CMPW'(col) < CMPW'(w_q));
		acc_addr = AW'(row) * AW'(GRID_COLS) + AW'(col);
		swp_addr = AW'(r_q) * AW'(GRID_COLS) + AW'(c_q);
		dst_addr = AW'(dr_q) * AW'(GRID_COLS) + AW'(dc_q);

		lim_r  = (cmd.sweep == SW_CLEAR) ? RC'(GRID_ROWS) : h_q;
		lim_c  = (cmd.sweep == SW_CLEAR) ? CC'(GRID_COLS) : w_q;
		r_last = (r_q == RC'(lim_r - RC'(1)));
		c_last = (c_q == CC'(lim_c - CC'(1)));

		cz_cur = fw_q ? cz_fw_q : cz_rd_q;
		co_cur = fw_q ? co_fw_q : co_rd_q;
		copy   = !rm_rd_q && !(cz_cur || co_cur);

		vz   = (rdata_q == PIX_W'(0));
		vo   = (rdata_q == PIX_W'(1));
		rz_n = (tg_c_s1 == '0) ? vz : (rz_q && vz);
		ro_n = (tg_c_s1 == '0) ? vo : (ro_q && vo);
		cz_n = (tg_r_s1 == '0) ? vz : (cz_cur && vz);
		co_n = (tg_r_s1 == '0) ? vo : (co_cur && vo);

		we    = 1'b0;
		waddr = swp_addr;
		wdata = '0;
		if (cmd.acc && req_type == REQ_WRITE && in_grid) begin
			we    = 1'b1;
			waddr = acc_addr;
			wdata = pixel_in;
		end else if (cmd.inv_wb && s1_ingrid_q) begin
			we    = 1'b1;
			waddr = s1_addr_q;
			wdata = vz ? PIX_W'(1) : PIX_W'(0);
		end else if (tg_pack_s1 && copy) begin
			we    = 1'b1;
			waddr = dst_addr;
			wdata = rdata_q;
		end else if (cmd.sweep == SW_CLEAR && (r_q >= keep_h_q || c_q >= keep_w_q)) begin
			we    = 1'b1;
		end

		re    = cmd.acc || cmd.sweep == SW_SCAN || cmd.sweep == SW_PACK;
		raddr = cmd.acc ? acc_addr : swp_addr;
	end

	assign sts.sweep_last = r_last && c_last;
	assign sts.img_empty  = (h_q == '0) || (w_q == '0);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= RC'(GRID_ROWS);
			w_q         <= CC'(GRID_COLS);
			keep_h_q    <= '0;
			keep_w_q    <= '0;
			r_q         <= '0;
			c_q         <= '0;
			dr_q        <= '0;
			dc_q        <= '0;
			nh_q        <= '0;
			nw_q        <= '0;
			tg_scan_s1  <= 1'b0;
			tg_pack_s1  <= 1'b0;
		end else begin
			if (cmd.sweep != SW_NONE) begin
				if (c_last) begin
					c_q <= '0;
					r_q <= r_last ? '0 : RC'(r_q + RC'(1));
				end else begin
					c_q <= CC'(c_q + CC'(1));
				end
			end

			if (cmd.cmp_start) begin
				dr_q <= '0;
				dc_q <= '0;
				nh_q <= '0;
				nw_q <= '0;
			end else begin
				if (tg_pack_s1) begin
					if (tg_clast_s1) begin
						dc_q <= '0;
						if (!rm_rd_q) dr_q <= RC'(dr_q + RC'(1));
					end else if (copy) begin
						dc_q <= CC'(dc_q + CC'(1));
					end
				end
				if (tg_scan_s1 && tg_rlast_s1 && !(cz_n || co_n)) nw_q <= CC'(nw_q + CC'(1));
				if (tg_scan_s1 && tg_clast_s1 && !(rz_n || ro_n)) nh_q <= RC'(nh_q + RC'(1));
			end

			if (cmd.set_size) begin
				h_q      <= nh_q;
				keep_h_q <= nh_q;
				w_q      <= (nh_q == '0) ? '0 : nw_q;
				keep_w_q <= (nh_q == '0) ? '0 : nw_q;
			end

			tg_scan_s1 <= (cmd.sweep == SW_SCAN);
			tg_pack_s1 <= (cmd.sweep == SW_PACK);
		end
	end

	always_ff @(posedge clk) begin
		tg_r_s1     <= r_q[RI-1:0];
		tg_c_s1     <= c_q[CI-1:0];
		tg_rlast_s1 <= r_last;
		tg_clast_s1 <= c_last;

		if (tg_scan_s1) begin
			rz_q          <= rz_n;
			ro_q          <= ro_n;
			cz_q[tg_c_s1] <= cz_n;
			co_q[tg_c_s1] <= co_n;
			if (tg_clast_s1) rm_q[tg_r_s1] <= rz_n || ro_n;
		end

		rm_rd_q <= rm_q[r_q[RI-1:0]];
		cz_rd_q <= cz_q[c_q[CI-1:0]];
		co_rd_q <= co_q[c_q[CI-1:0]];
		fw_q    <= tg_scan_s1 && (tg_c_s1 == c_q[CI-1:0]);
		cz_fw_q <= cz_n;
		co_fw_q <= co_n;

		if (cmd.acc) begin
			s1_type_q   <= req_type;
			s1_rd_ok_q  <= (req_type == REQ_READ) && in_img;
			s1_oor_q    <= (req_type == REQ_READ || req_type == REQ_INVERT) && !in_img;
			s1_ingrid_q <= in_grid;
			s1_addr_q   <= acc_addr;
		end

		if (cmd.out_load) begin
			pix_q <= (s1_rd_ok_q && s1_type_q == REQ_READ) ? rdata_q : '0;
			oh_q  <= SIZE_W'(h_q);
			ow_q  <= SIZE_W'(w_q);
			oor_q <= s1_oor_q;
		end
	end

	assign pixel_out    = pix_q;
	assign cur_height   = oh_q;
	assign cur_width    = ow_q;
	assign out_of_range = oor_q;
endmodule

FILE: sv/uniform_row_col_remover.sv
// Top level of the uniform row and column remover.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, row, col, pixel_in
//   res      out  valid/ready    pixel_out, cur_height, cur_width, out_of_range
//
// Write and read requests can be taken back to back while the result stage is not
// stalled; an invert holds off the next request until its read-modify-write on
// the store's single write port is done. A compaction runs a scan sweep and a
// pack sweep over the H by W image and then a clearing sweep over the whole grid,
// one store entry a cycle; for an empty image only the clearing sweep runs.
// After reset a clearing pass over all GRID_ROWS*GRID_COLS entries runs before the
// first request is taken. A stalled result holds in the output register while
// one further request completes behind it.
module uniform_row_col_remover #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input logic        clk,
	input logic        arst_n,
	urcr_req_if.sink   req,
	urcr_res_if.source res
);
	import urcr_pkg::*;

	urcr_cmd_t cmd;
	urcr_sts_t sts;

	urcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_type   (req.req_type),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	urcr_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req.req_type),
		.row          (req.row),
		.col          (req.col),
		.pixel_in     (req.pixel_in),
		.pixel_out    (res.pixel_out),
		.cur_height   (res.cur_height),
		.cur_width    (res.cur_width),
		.out_of_range (res.out_of_range)
	);
endmodule

FILE: test/uniform_row_col_remover_test.sv
// Self-checking testbench for the uniform row and column remover, with a built-in image predictor.
`timescale 1ns / 100ps

module uniform_row_col_remover_test;
	import urcr_pkg::*;

	localparam int GRID_ROWS    = 64;
	localparam int GRID_COLS    = 64;
	localparam int IDLE_PCT     = 9;
	localparam int RANDOM_ITEMS = 1050;
	localparam int KILL_MIN_DIM = 6;
	localparam int SEED_LINES   = 24;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [SIZE_W-1:0] height;
		logic [SIZE_W-1:0] width;
		logic              oor;
	} pixel_result_t;

	logic clk;
	logic arst_n;

	urcr_req_if req_ch ();
	urcr_res_if res_ch ();

	uniform_row_col_remover dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	logic [PIX_W-1:0] shadow_grid [GRID_ROWS][GRID_COLS];
	int               shadow_h;
	int               shadow_w;
	pixel_result_t    pending_results [$];
	int               sent_count     = 0;
	int               mismatch_count = 0;
	int               cycle_count;
	bit               gaps_on        = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void compact_shadow();
		bit row_gone [GRID_ROWS];
		bit col_gone [GRID_COLS];
		bit all_zero;
		bit all_one;
		int kept_w;
		int dr;
		int dc;
		for (int r = 0; r < shadow_h; r++) begin
			all_zero = 1'b1;
			all_one  = 1'b1;
			for (int c = 0; c < shadow_w; c++) begin
				if (shadow_grid[r][c] != 0) all_zero = 1'b0;
				if (shadow_grid[r][c] != 1) all_one = 1'b0;
			end
			row_gone[r] = all_zero | all_one;
		end
		for (int c = 0; c < shadow_w; c++) begin
			all_zero = 1'b1;
			all_one  = 1'b1;
			for (int r = 0; r < shadow_h; r++) begin
				if (shadow_grid[r][c] != 0) all_zero = 1'b0;
				if (shadow_grid[r][c] != 1) all_one = 1'b0;
			end
			col_gone[c] = all_zero | all_one;
		end
		kept_w = 0;
		for (int c = 0; c < shadow_w; c++)
			if (!col_gone[c]) kept_w++;
		dr = 0;
		for (int r = 0; r < shadow_h; r++) begin
			if (!row_gone[r]) begin
				dc = 0;
				for (int c = 0; c < shadow_w; c++) begin
					if (!col_gone[c]) begin
						shadow_grid[dr][dc] = shadow_grid[r][c];
						dc++;
					end
				end
				dr++;
			end
		end
		if (dr == 0) kept_w = 0;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				if (r >= dr || c >= kept_w) shadow_grid[r][c] = '0;
		shadow_h = dr;
		shadow_w = kept_w;
	endfunction

	function automatic pixel_result_t predict_request(req_kind_t kind, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c, logic [PIX_W-1:0] p);
		pixel_result_t outcome;
		bit in_image;
		outcome  = '0;
		in_image = (r < shadow_h) && (c < shadow_w);
		case (kind)
			REQ_WRITE: shadow_grid[r][c] = p;
			REQ_READ: begin
				if (in_image) outcome.pixel = shadow_grid[r][c];
				else outcome.oor = 1'b1;
			end
			REQ_INVERT: begin
				shadow_grid[r][c] = (shadow_grid[r][c] == 0) ? PIX_W'(1) : PIX_W'(0);
				outcome.oor = !in_image;
			end
			default: compact_shadow();
		endcase
		outcome.height = SIZE_W'(shadow_h);
		outcome.width  = SIZE_W'(shadow_w);
		return outcome;
	endfunction

	function automatic void shuffle_lines(ref int lines [GRID_ROWS], input int n);
		int j;
		int tmp;
		for (int i = 0; i < n; i++)
			lines[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = lines[i];
			lines[i] = lines[j];
			lines[j] = tmp;
		end
	endfunction

	task automatic report_mismatch(string what, pixel_result_t want, pixel_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected pixel %0d height %0d width %0d oor %0b", $time, what,
				want.pixel, want.height, want.width, want.oor,
				"; got pixel %0d height %0d width %0d oor %0b",
				got.pixel, got.height, got.width, got.oor);
	endtask

	task automatic send_request(req_kind_t kind, int r, int c, int p);
		pixel_result_t predicted;
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 20);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.row      <= ROW_W'(r);
		req_ch.col      <= COL_W'(c);
		req_ch.pixel_in <= PIX_W'(p);
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_request(kind, ROW_W'(r), COL_W'(c), PIX_W'(p));
		pending_results.insert(pending_results.size(), predicted);
		sent_count++;
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic send_noise();
		int pick;
		int r;
		int c;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 80 && shadow_h > 0 && shadow_w > 0) begin
			r = $urandom_range(shadow_h - 1);
			c = $urandom_range(shadow_w - 1);
		end else begin
			r = $urandom_range(GRID_ROWS - 1);
			c = $urandom_range(GRID_COLS - 1);
		end
		if (pick < 40) begin
			send_request(REQ_WRITE, r, c,
				($urandom_range(9) == 0) ? $urandom_range(15, 10) : $urandom_range(9));
		end else if (pick < 75) begin
			send_request(REQ_READ, r, c, $urandom_range(15));
		end else if (pick < 97) begin
			send_request(REQ_INVERT, r, c, $urandom_range(15));
		end else begin
			send_request(REQ_COMPACT, r, c, $urandom_range(15));
		end
	endtask

	task automatic test_pixel_access();
		send_request(REQ_READ, 0, 0, 0);
		send_request(REQ_WRITE, 63, 63, 15);
		send_request(REQ_READ, 63, 63, 0);
		send_request(REQ_INVERT, 63, 63, 0);
		send_request(REQ_READ, 63, 63, 15);
		send_request(REQ_INVERT, 0, 63, 0);
		send_request(REQ_READ, 0, 63, 0);
		send_request(REQ_WRITE, 63, 0, 9);
		send_request(REQ_READ, 63, 0, 0);
		send_request(REQ_WRITE, 0, 0, 10);
		send_request(REQ_INVERT, 0, 0, 0);
		send_request(REQ_READ, 0, 0, 0);
		send_request(REQ_WRITE, 21, 42, 5);
		send_request(REQ_READ, 21, 42, 0);
		send_request(REQ_READ, 42, 21, 0);
	endtask

	task automatic test_first_compaction();
		int row_order [GRID_ROWS];
		int col_order [GRID_COLS];
		shuffle_lines(row_order, GRID_ROWS);
		shuffle_lines(col_order, GRID_COLS);
		for (int i = 0; i < SEED_LINES; i++)
			send_request(REQ_WRITE, row_order[i], col_order[i], $urandom_range(15, 2));
		send_request(REQ_COMPACT, $urandom_range(63), $urandom_range(63), $urandom_range(15));
		wait_for_results();
	endtask

	task automatic test_random_episodes();
		int lines [GRID_ROWS];
		int kill_rows;
		int kill_cols;
		int fill;
		int episode;
		episode = 0;
		while (sent_count < RANDOM_ITEMS) begin
			gaps_on = (episode != 3);
			repeat ($urandom_range(40, 15)) send_noise();
			kill_rows = (shadow_h > KILL_MIN_DIM) ? $urandom_range(3) : 0;
			kill_cols = (shadow_w > KILL_MIN_DIM) ? $urandom_range(3) : 0;
			fill      = $urandom_range(1);
			shuffle_lines(lines, shadow_h);
			for (int i = 0; i < kill_rows; i++)
				for (int c = 0; c < shadow_w; c++)
					send_request(REQ_WRITE, lines[i], c, fill);
			shuffle_lines(lines, shadow_w);
			for (int i = 0; i < kill_cols; i++)
				for (int r = 0; r < shadow_h; r++)
					send_request(REQ_WRITE, r, lines[i], fill);
			send_request(REQ_COMPACT, $urandom_range(63), $urandom_range(63), $urandom_range(15));
			if ($urandom_range(3) == 0) wait_for_results();
			episode++;
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_empty_image();
		wait_for_results();
		if (shadow_w >= 2 && shadow_h * shadow_w <= 600)
			for (int r = 0; r < shadow_h; r++)
				for (int c = 0; c < shadow_w; c++)
					send_request(REQ_WRITE, r, c, c % 2);
		send_request(REQ_COMPACT, 0, 0, 0);
		send_request(REQ_READ, 0, 0, 0);
		send_request(REQ_INVERT, 0, 0, 0);
		send_request(REQ_WRITE, 0, 0, 7);
		send_request(REQ_READ, 63, 63, 0);
		send_request(REQ_COMPACT, 63, 63, 15);
		send_request(REQ_READ, 0, 0, 0);
		send_request(REQ_COMPACT, 0, 0, 0);
		send_request(REQ_INVERT, 63, 63, 0);
		send_request(REQ_READ, 63, 63, 0);
	endtask

	initial begin
		pixel_result_t got;
		pixel_result_t want;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.pixel_out, res_ch.cur_height, res_ch.cur_width, res_ch.out_of_range};
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request outstanding", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.pixel !== want.pixel || got.height !== want.height ||
							got.width !== want.width || got.oor !== want.oor) begin
						report_mismatch("result mismatch", want, got);
					end
				end
			end
			res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		foreach (shadow_grid[r, c])
			shadow_grid[r][c] = '0;
		shadow_h        = GRID_ROWS;
		shadow_w        = GRID_COLS;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_WRITE;
		req_ch.row      <= '0;
		req_ch.col      <= '0;
		req_ch.pixel_in <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_pixel_access();
		test_first_compaction();
		test_random_episodes();
		test_empty_image();
		wait_for_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
